/* src/spc_pkg.sv */
package spc_pkg;

    // Pipeline depths of the two cell chains
    localparam int ROOT_STEPS = 34;
    localparam int NORM_STEPS = 15;

    // Configuration register indexes
    localparam logic [1:0] REG_RADIUS_FIRST  = 2'd0;
    localparam logic [1:0] REG_RADIUS_SECOND = 2'd1;

    // Square-root cell payload, with the contact-point dividers riding along
    typedef struct packed {
        logic [67:0]       s;
        logic [34:0]       rem;
        logic [32:0]       root;
        logic [2:0][63:0]  cnum;
        logic [2:0][31:0]  crem;
        logic [2:0][33:0]  cq;
        logic [2:0]        csign;
        logic [31:0]       wsum;
        logic [2:0][31:0]  dmag;
        logic [2:0]        dsign;
        logic [31:0]       rsum;
    } root_t;

    // Normal divider cell payload
    typedef struct packed {
        logic [32:0]       dlen;
        logic [2:0][32:0]  rem;
        logic [2:0][14:0]  num;
        logic [2:0][14:0]  q;
        logic [2:0]        dsign;
        logic              degen;
        logic [33:0]       gap;
        logic [2:0][31:0]  contact;
    } norm_t;

endpackage

/* src/spc_root_cell.sv */
module spc_root_cell
    import spc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_vld,
    input  root_t cur,
    output logic  out_vld,
    output root_t nxt
);

    logic        vld_reg;
    root_t       data_reg;
    root_t       data_next;
    logic [36:0] rem_t;
    logic [36:0] trial;
    logic [32:0] ct;

    // One root bit and one quotient bit per lane
    always_comb
    begin
        data_next = cur;
        rem_t = {cur.rem, cur.s[67:66]};
        trial = {2'b00, cur.root, 2'b01};
        data_next.s = {cur.s[65:0], 2'b00};
        if (rem_t >= trial)
        begin
            data_next.rem  = 35'(rem_t - trial);
            data_next.root = {cur.root[31:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_t[34:0];
            data_next.root = {cur.root[31:0], 1'b0};
        end
        for (int k = 0; k < 3; k++)
        begin
            ct = {cur.crem[k], cur.cnum[k][63]};
            data_next.cnum[k] = {cur.cnum[k][62:0], 1'b0};
            if (ct >= {1'b0, cur.wsum})
            begin
                data_next.crem[k] = 32'(ct - {1'b0, cur.wsum});
                data_next.cq[k]   = {cur.cq[k][32:0], 1'b1};
            end
            else
            begin
                data_next.crem[k] = ct[31:0];
                data_next.cq[k]   = {cur.cq[k][32:0], 1'b0};
            end
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= in_vld;
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_vld = vld_reg;
    assign nxt     = data_reg;

endmodule

/* src/spc_norm_cell.sv */
module spc_norm_cell
    import spc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_vld,
    input  norm_t cur,
    output logic  out_vld,
    output norm_t nxt
);

    logic        vld_reg;
    norm_t       data_reg;
    norm_t       data_next;
    logic [33:0] t;

    // One quotient bit per normal component
    always_comb
    begin
        data_next = cur;
        for (int k = 0; k < 3; k++)
        begin
            t = {cur.rem[k], cur.num[k][14]};
            data_next.num[k] = {cur.num[k][13:0], 1'b0};
            if (t >= {1'b0, cur.dlen})
            begin
                data_next.rem[k] = 33'(t - {1'b0, cur.dlen});
                data_next.q[k]   = {cur.q[k][13:0], 1'b1};
            end
            else
            begin
                data_next.rem[k] = t[32:0];
                data_next.q[k]   = {cur.q[k][13:0], 1'b0};
            end
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= in_vld;
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_vld = vld_reg;
    assign nxt     = data_reg;

endmodule

/* src/sphere_pair_contact.sv */
// Sphere pair contact: gap, contact point and unit normal of two spheres.
// Input channel (in_valid / in_stall) carries both centres in signed Q16.16;
// output channel (out_valid / out_stall) returns gap (Q16.16), the
// radius-weighted contact point (Q16.16), the normal (Q1.14) and the
// degenerate flag for coincident centres.
// Radii are written through wr_en / wr_index / wr_data; the user must write
// them only while the block is idle (not enforced); both reset to 1.0.
// From an accepted transaction to its result the data passes three
// front stages (differences and products, squares and sums, radicand),
// 34 square-root cells that also run the contact dividers, one rounding
// stage, 15 normal divider cells and the output register.
// Throughput is one transaction per cycle unless a held result is stalled;
// the whole chain moves as one. When the receiver stalls with a result held,
// the chain freezes and in_stall rises in the same cycle; nothing is dropped.
// Reset clears all valid bits and restores the radius registers.
module sphere_pair_contact
    import spc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [30:0]        wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_z,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic signed [31:0] second_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [33:0] gap,
    output logic signed [31:0] contact_x,
    output logic signed [31:0] contact_y,
    output logic signed [31:0] contact_z,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic               degenerate
);

    logic [30:0] radius_first_reg;
    logic [30:0] radius_second_reg;
    logic        adv;

    logic [2:0][31:0] p1;
    logic [2:0][31:0] p2;

    // Front stage registers
    logic             s1_vld_reg;
    logic [2:0][32:0] s1_d_reg;
    logic [2:0][62:0] s1_pa_reg;
    logic [2:0][62:0] s1_pb_reg;
    logic [31:0]      s1_wsum_reg;
    logic [31:0]      s1_rsum_reg;
    logic             s2_vld_reg;
    logic [2:0][63:0] s2_sq_reg;
    logic [2:0][63:0] s2_cn_reg;
    logic [2:0][31:0] s2_dmag_reg;
    logic [2:0]       s2_dsign_reg;
    logic [31:0]      s2_wsum_reg;
    logic [31:0]      s2_rsum_reg;
    logic [2:0][63:0] cn_mag;

    logic [31:0] rsum;
    logic [31:0] w1;
    logic [31:0] w2;

    root_t root_pipe [0:ROOT_STEPS];
    logic  root_vld  [0:ROOT_STEPS];
    root_t root_init;
    logic  root_init_vld_reg;

    norm_t norm_pipe [0:NORM_STEPS];
    logic  norm_vld  [0:NORM_STEPS];
    norm_t mid_next;
    norm_t mid_reg;
    logic  mid_vld_reg;

    logic                    out_valid_reg;
    logic [33:0]             gap_reg;
    logic [2:0][31:0]        contact_reg;
    logic [2:0][15:0]        normal_reg;
    logic                    degen_reg;
    logic [2:0][15:0]        normal_next;

    // Move the chain unless a held result is stalled
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // Radius registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_first_reg  <= 31'd65536;
            radius_second_reg <= 31'd65536;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_RADIUS_FIRST:  radius_first_reg  <= wr_data;
                REG_RADIUS_SECOND: radius_second_reg <= wr_data;
                default: ;
            endcase
        end
    end

    assign p1 = {first_z, first_y, first_x};
    assign p2 = {second_z, second_y, second_x};

    // Use equal weights when both radii are zero
    always_comb
    begin
        rsum = {1'b0, radius_first_reg} + {1'b0, radius_second_reg};
        w1   = {1'b0, radius_first_reg};
        w2   = {1'b0, radius_second_reg};
        if (rsum == 32'd0)
        begin
            w1 = 32'd1;
            w2 = 32'd1;
        end
    end

    // Magnitude of the weighted numerators
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            cn_mag[k] = s2_cn_reg[k][63] ? 64'(-s2_cn_reg[k]) : s2_cn_reg[k];
    end

    // Valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg        <= 1'b0;
            s2_vld_reg        <= 1'b0;
            root_init_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg        <= in_valid;
            s2_vld_reg        <= s1_vld_reg;
            root_init_vld_reg <= s2_vld_reg;
        end
    end

    // Front stages: differences and weighted products, squares, radicand
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_d_reg[k]  <= {p1[k][31], p1[k]} - {p2[k][31], p2[k]};
                s1_pa_reg[k] <= 63'($signed(w1) * $signed(p1[k]));
                s1_pb_reg[k] <= 63'($signed(w2) * $signed(p2[k]));
                s2_dmag_reg[k]  <= s1_d_reg[k][32] ? 32'(-s1_d_reg[k]) : s1_d_reg[k][31:0];
                s2_dsign_reg[k] <= s1_d_reg[k][32];
                s2_sq_reg[k] <= (s1_d_reg[k][32] ? 64'(32'(-s1_d_reg[k]))
                                                 : 64'(s1_d_reg[k][31:0]))
                              * (s1_d_reg[k][32] ? 64'(32'(-s1_d_reg[k]))
                                                 : 64'(s1_d_reg[k][31:0]));
                s2_cn_reg[k] <= {s1_pa_reg[k][62], s1_pa_reg[k]}
                              + {s1_pb_reg[k][62], s1_pb_reg[k]};
            end
            s1_wsum_reg <= w1 + w2;
            s1_rsum_reg <= rsum;
            s2_wsum_reg <= s1_wsum_reg;
            s2_rsum_reg <= s1_rsum_reg;

            root_init.s    <= {4'b0000, s2_sq_reg[0]} + {4'b0000, s2_sq_reg[1]}
                            + {4'b0000, s2_sq_reg[2]};
            root_init.rem  <= '0;
            root_init.root <= '0;
            for (int k = 0; k < 3; k++)
            begin
                root_init.cnum[k] <= {cn_mag[k][33:0], 30'd0};
                root_init.crem[k] <= {2'b00, cn_mag[k][63:34]};
                root_init.cq[k]   <= '0;
            end
            root_init.csign <= {s2_cn_reg[2][63], s2_cn_reg[1][63], s2_cn_reg[0][63]};
            root_init.wsum  <= s2_wsum_reg;
            root_init.dmag  <= s2_dmag_reg;
            root_init.dsign <= s2_dsign_reg;
            root_init.rsum  <= s2_rsum_reg;
        end
    end

    assign root_pipe[0] = root_init;
    assign root_vld[0]  = root_init_vld_reg;

    // Square-root and contact divider chain
    for (genvar i = 0; i < ROOT_STEPS; i++)
    begin : g_root
        spc_root_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .in_vld  (root_vld[i]),
            .cur     (root_pipe[i]),
            .out_vld (root_vld[i+1]),
            .nxt     (root_pipe[i+1])
        );
    end

    // Round root and contact quotients, set up the normal dividers
    always_comb
    begin
        root_t       r;
        logic [33:0] rlen;
        logic [33:0] qr;
        r = root_pipe[ROOT_STEPS];
        rlen = {1'b0, r.root} + 34'(r.rem > {2'b00, r.root});
        mid_next.dlen  = rlen[32:0];
        mid_next.gap   = {1'b0, rlen[32:0]} - {2'b00, r.rsum};
        mid_next.degen = (rlen == 34'd0);
        mid_next.dsign = r.dsign;
        for (int k = 0; k < 3; k++)
        begin
            qr = r.cq[k] + 34'({r.crem[k], 1'b0} >= {1'b0, r.wsum});
            mid_next.contact[k] = r.csign[k] ? 32'(-qr) : qr[31:0];
            mid_next.rem[k] = {2'b00, r.dmag[k][31:1]};
            mid_next.num[k] = {r.dmag[k][0], 14'd0};
            mid_next.q[k]   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_vld_reg <= 1'b0;
        else if (adv)
            mid_vld_reg <= root_vld[ROOT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            mid_reg <= mid_next;
    end

    assign norm_pipe[0] = mid_reg;
    assign norm_vld[0]  = mid_vld_reg;

    // Normal divider chain
    for (genvar i = 0; i < NORM_STEPS; i++)
    begin : g_norm
        spc_norm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .in_vld  (norm_vld[i]),
            .cur     (norm_pipe[i]),
            .out_vld (norm_vld[i+1]),
            .nxt     (norm_pipe[i+1])
        );
    end

    // Round normals and zero them for coincident centres
    always_comb
    begin
        norm_t       n;
        logic [15:0] qr;
        n = norm_pipe[NORM_STEPS];
        for (int k = 0; k < 3; k++)
        begin
            qr = {1'b0, n.q[k]}
               + 16'({n.rem[k], 1'b0} >= {1'b0, n.dlen});
            if (n.degen)
                normal_next[k] = '0;
            else
                normal_next[k] = n.dsign[k] ? 16'(-qr) : qr;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= norm_vld[NORM_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gap_reg     <= norm_pipe[NORM_STEPS].gap;
            contact_reg <= norm_pipe[NORM_STEPS].contact;
            normal_reg  <= normal_next;
            degen_reg   <= norm_pipe[NORM_STEPS].degen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign gap        = gap_reg;
    assign contact_x  = contact_reg[0];
    assign contact_y  = contact_reg[1];
    assign contact_z  = contact_reg[2];
    assign normal_x   = normal_reg[0];
    assign normal_y   = normal_reg[1];
    assign normal_z   = normal_reg[2];
    assign degenerate = degen_reg;

endmodule

/* src/spc_checker.sv */
module spc_checker
    import spc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [33:0] gap,
    input logic signed [15:0] normal_x,
    input logic signed [15:0] normal_y,
    input logic signed [15:0] normal_z,
    input logic               degenerate
);

    // Hold a stalled result: valid, gap and normal_x stay stable
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(gap) && $stable(normal_x))
        else $error("stalled result changed");

    // Accept input whenever the output side drains
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output free");

    // Zero the normal for coincident centres
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
        else $error("degenerate normal not zero");

    // Keep normal components within unit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384
                   && normal_y <= 16'sd16384 && normal_y >= -16'sd16384
                   && normal_z <= 16'sd16384 && normal_z >= -16'sd16384)
        else $error("normal out of range");

endmodule

bind sphere_pair_contact spc_checker u_spc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .gap        (gap),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .degenerate (degenerate)
);
